FILE: src/transitive_closure_defines.svh
// ----------------------------------------------------------------------------
// transitive_closure_defines
// assertion macros for the transitive closure block
// ----------------------------------------------------------------------------
`ifndef TRANSITIVE_CLOSURE_DEFINES_SVH
`define TRANSITIVE_CLOSURE_DEFINES_SVH

`ifndef SYNTHESIS

// property checked only while out of reset
`define TC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("transitive_closure assertion failed");

// property checked on every edge, reset included
`define TC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("transitive_closure assertion failed");

`else

`define TC_ASSERT(lbl, clk, rst_n, prop)
`define TC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: src/tc_pkg.sv
// ----------------------------------------------------------------------------
// tc_pkg
// types and constants of the transitive closure block
// ----------------------------------------------------------------------------
package tc_pkg;

    // fixed field widths
    localparam int ROW_W      = 16;
    localparam int ROW_IDX_W  = 4;
    localparam int VCOUNT_W   = 5;

    // default matrix depth
    localparam int MAX_VERTICES_DEF = 16;

    // vertex count after reset
    localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 5'd16;

    // sequencer states
    typedef enum logic [1:0] {
        S_LOAD,
        S_CLOSE,
        S_EMIT
    } t_state;

endpackage

FILE: src/transitive_closure.sv
// ----------------------------------------------------------------------------
// transitive_closure
// Warshall transitive closure of a directed graph of up to MAX_VERTICES nodes
// ----------------------------------------------------------------------------
// The block takes an adjacency matrix one row per item, row 0 first, with as
// many rows as the vertex count register says (0 counts as 1, values above
// MAX_VERTICES saturate). Row bits at or above the vertex count are cleared
// on load; while loading, a row item is taken whenever one is offered. The
// last row starts the closure: one pivot per cycle, a shared OR array
// updating every row that reaches the pivot in parallel. The closure rows
// then leave through a single output register, one per cycle when the sink
// is ready, row 0 first, with last_row on the final one. A full data set
// passes through loading, the pivot steps and the emits in turn; no new row is
// accepted during the pivot and emit phases. Writing the vertex count
// restarts loading and drops rows already taken in; it must only be written
// while the block is idle.
// ----------------------------------------------------------------------------
`include "transitive_closure_defines.svh"

module transitive_closure
    import tc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_wr_en,
    input  logic [VCOUNT_W-1:0]  i_cfg_wr_data,
    // row items in
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [ROW_W-1:0]     i_row_bits,
    // closure rows out
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [ROW_IDX_W-1:0] o_row_index,
    output logic [ROW_W-1:0]     o_closure_row,
    output logic                 o_last_row
);

    // counter wide enough to hold MAX_VERTICES itself, index for the rows
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int IDX_W = $clog2(MAX_VERTICES);

    // state and registers
    t_state                r_state, n_state;
    logic [VCOUNT_W-1:0]   r_vertex_count;
    logic [CNT_W-1:0]      r_rows_loaded, n_rows_loaded;
    logic [CNT_W-1:0]      r_pivot, n_pivot;
    logic [CNT_W-1:0]      r_emit, n_emit;
    logic [ROW_W-1:0]      r_matrix [MAX_VERTICES];

    // output register
    logic                  r_out_valid, n_out_valid;
    logic [ROW_W-1:0]      r_out_row;
    logic [ROW_IDX_W-1:0]  r_out_index;
    logic                  r_out_last;

    // control
    logic [CNT_W-1:0]      active_n;
    logic [CNT_W-1:0]      last_idx;
    logic [ROW_W-1:0]      row_mask;
    logic                  in_fire;
    logic                  last_load;
    logic                  close_step;
    logic                  emit_fire;
    logic [ROW_W-1:0]      pivot_row;
    logic [MAX_VERTICES-1:0] row_hit;

    // ------------------------------------------------------------------
    // vertex count in use: zero counts as one, saturated at the depth
    // ------------------------------------------------------------------
    always_comb begin
        if (r_vertex_count == '0) begin
            active_n = CNT_W'(1);
        end else if (32'(r_vertex_count) > MAX_VERTICES) begin
            active_n = CNT_W'(MAX_VERTICES);
        end else begin
            active_n = CNT_W'(r_vertex_count);
        end
    end

    assign last_idx = active_n - CNT_W'(1);

    // columns at or above the vertex count are cleared on load
    always_comb begin
        for (int j = 0; j < ROW_W; j++) begin
            row_mask[j] = (j < 32'(active_n));
        end
    end

    // ------------------------------------------------------------------
    // shared OR unit: pivot row broadcast to every row that reaches it
    // ------------------------------------------------------------------
    assign pivot_row = r_matrix[r_pivot[IDX_W-1:0]];

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            // pivots past the row width never hit, those bits are always clear
            row_hit[i] = (32'(r_pivot) < ROW_W) && r_matrix[i][ROW_IDX_W'(r_pivot)];
        end
    end

    // ------------------------------------------------------------------
    // sequencer: load rows, step the pivots, emit the closure
    // ------------------------------------------------------------------
    always_comb begin
        n_state       = r_state;
        n_rows_loaded = r_rows_loaded;
        n_pivot       = r_pivot;
        n_emit        = r_emit;
        n_out_valid   = r_out_valid;
        o_ready       = 1'b0;
        in_fire       = 1'b0;
        close_step    = 1'b0;
        emit_fire     = 1'b0;
        last_load     = (r_rows_loaded == last_idx);

        // sink taking the current row frees the output register
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_LOAD: begin
                o_ready = 1'b1;
                in_fire = i_valid;
                if (i_valid) begin
                    if (last_load) begin
                        n_rows_loaded = '0;
                        n_pivot       = '0;
                        n_state       = S_CLOSE;
                    end else begin
                        n_rows_loaded = r_rows_loaded + CNT_W'(1);
                    end
                end
            end
            S_CLOSE: begin
                close_step = 1'b1;
                n_pivot    = r_pivot + CNT_W'(1);
                if (r_pivot == last_idx) begin
                    n_emit  = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    emit_fire   = 1'b1;
                    n_out_valid = 1'b1;
                    n_emit      = r_emit + CNT_W'(1);
                    if (r_emit == last_idx) begin
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        // a vertex count write restarts the data set
        if (i_cfg_wr_en) begin
            n_rows_loaded = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_LOAD;
            r_vertex_count <= VCOUNT_RST;
            r_rows_loaded  <= '0;
            r_pivot        <= '0;
            r_emit         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_rows_loaded  <= n_rows_loaded;
            r_pivot        <= n_pivot;
            r_emit         <= n_emit;
            r_out_valid    <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_vertex_count <= i_cfg_wr_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // reach matrix: written on load, widened per pivot, shifted up on emit
    // so row 0 always holds the next row to go out
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_matrix[r_rows_loaded[IDX_W-1:0]] <= i_row_bits & row_mask;
        end else if (close_step) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
                if (row_hit[i]) begin
                    r_matrix[i] <= r_matrix[i] | pivot_row;
                end
            end
        end else if (emit_fire) begin
            for (int i = 0; i < MAX_VERTICES - 1; i++) begin
                r_matrix[i] <= r_matrix[i+1];
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_out_row   <= r_matrix[0];
            r_out_index <= ROW_IDX_W'(r_emit);
            r_out_last  <= (r_emit == last_idx);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_closure_row = r_out_row;
    assign o_row_index   = r_out_index;
    assign o_last_row    = r_out_last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // pivot never runs past the vertex count
    `TC_ASSERT(a_pivot_range, i_clk, i_rst_n, (r_state == S_CLOSE) |-> (r_pivot < active_n))
    // load position stays inside the current data set
    `TC_ASSERT(a_load_range, i_clk, i_rst_n, (r_state == S_LOAD) |-> (r_rows_loaded < active_n))
    // leaving the emit phase means the final row has just gone to the output
    `TC_ASSERT(a_emit_ends_last, i_clk, i_rst_n, ($past(r_state) == S_EMIT && r_state == S_LOAD) |-> (r_out_valid && r_out_last))
    // nothing is presented right after reset
    `TC_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid)

endmodule

FILE: tb/sv/transitive_closure_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// transitive_closure_tb
// self-checking bench for the warshall transitive closure block
// ----------------------------------------------------------------------------
// adjacency rows are pushed in through the row channel and every closure row
// that comes out is checked against a local model of the block. a few
// directed graphs come first (default vertex count, count extremes, restart
// of loading by a register write), then random data sets of mostly small
// sizes, run under three idling patterns on the two channels.
// ----------------------------------------------------------------------------
module transitive_closure_tb;
    import tc_pkg::*;

    // cycles to let pass before a register write when rows may still be
    // in flight without any result pending
    localparam int LOAD_SETTLE = 8;
    // quiet time at the end, enough for a full closure of the largest graph
    localparam int END_QUIET   = 3 * MAX_VERTICES_DEF + 20;

    typedef struct packed {
        logic [ROW_IDX_W-1:0] index;
        logic [ROW_W-1:0]     row;
        logic                 last;
    } t_closure_row;

    // ------------------------------------------------------------------------
    // dut signals, the driven ones known from time zero
    // ------------------------------------------------------------------------
    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [VCOUNT_W-1:0]  cfg_wr_data = '0;
    logic                 row_valid   = 1'b0;
    logic                 row_ready;
    logic [ROW_W-1:0]     row_bits    = '0;
    logic                 res_valid;
    logic                 res_ready   = 1'b0;
    logic [ROW_IDX_W-1:0] res_index;
    logic [ROW_W-1:0]     res_row;
    logic                 res_last;

    // ------------------------------------------------------------------------
    // closure model state
    // ------------------------------------------------------------------------
    logic [VCOUNT_W-1:0]  vcount_reg;
    logic [ROW_W-1:0]     reach_rows [MAX_VERTICES_DEF];
    int unsigned          rows_taken;
    t_closure_row         closure_q [$];

    // idling percentages for the two channels, changed per phase
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_idle_pct = 0;
    int unsigned          rows_sent     = 0;
    int unsigned          error_count   = 0;

    transitive_closure i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_valid       (row_valid),
        .o_ready       (row_ready),
        .i_row_bits    (row_bits),
        .o_valid       (res_valid),
        .i_ready       (res_ready),
        .o_row_index   (res_index),
        .o_closure_row (res_row),
        .o_last_row    (res_last)
    );

    // 2 ns clock
    initial begin
        forever #1 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial begin
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // model of the block
    // ------------------------------------------------------------------------

    // zero counts as one vertex, anything above the matrix depth saturates
    function automatic int unsigned active_vertices();
        if (vcount_reg == 0)
            return 1;
        if (vcount_reg > MAX_VERTICES_DEF)
            return MAX_VERTICES_DEF;
        return 32'(vcount_reg);
    endfunction

    // take in one row; the last row of a set closes the graph and queues
    // every closure row, row 0 first
    function automatic void load_row_and_close(input logic [ROW_W-1:0] bits);
        int unsigned      n;
        logic [ROW_W:0]   wide_mask;
        t_closure_row     entry;
        n         = active_vertices();
        wide_mask = (17'd1 << n) - 17'd1;
        if (rows_taken >= n)
            rows_taken = 0;
        reach_rows[rows_taken] = bits & wide_mask[ROW_W-1:0];
        rows_taken++;
        if (rows_taken < n)
            return;
        // warshall: every row that reaches pivot k takes in row k
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < n; i++) begin
                if (reach_rows[i][k])
                    reach_rows[i] = reach_rows[i] | reach_rows[k];
            end
        end
        for (int r = 0; r < n; r++) begin
            entry.index = r[ROW_IDX_W-1:0];
            entry.row   = reach_rows[r];
            entry.last  = (r == n - 1);
            closure_q.push_back(entry);
        end
        rows_taken = 0;
    endfunction

    // ------------------------------------------------------------------------
    // receiver side: ready toggles at random, results checked in order
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        res_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin : check_results
        t_closure_row want;
        if (rst_n && res_valid && res_ready) begin
            if (closure_q.size() == 0) begin
                $error("closure row %0d arrived with nothing expected", res_index);
                error_count++;
            end else begin
                want = closure_q.pop_front();
                if (res_index !== want.index) begin
                    $error("row_index: expected %0d, got %0d", want.index, res_index);
                    error_count++;
                end
                if (res_row !== want.row) begin
                    $error("closure_row: expected %h, got %h", want.row, res_row);
                    error_count++;
                end
                if (res_last !== want.last) begin
                    $error("last_row: expected %0b, got %0b", want.last, res_last);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // shared stimulus tasks
    // ------------------------------------------------------------------------

    // send one row item; valid stays high after acceptance so that
    // back-to-back items need no gap
    task automatic send_row(input logic [ROW_W-1:0] bits);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            row_valid <= 1'b0;
            @(posedge clk);
        end
        row_valid <= 1'b1;
        row_bits  <= bits;
        do
            @(posedge clk);
        while (!row_ready);
        load_row_and_close(bits);
        rows_sent++;
    endtask

    // lower valid and wait for every queued closure row, then let any
    // rows still being loaded settle
    task automatic wait_idle();
        row_valid <= 1'b0;
        while (closure_q.size() != 0)
            @(posedge clk);
        repeat (LOAD_SETTLE) @(posedge clk);
    endtask

    // vertex count write, only ever issued from an idle block
    task automatic write_vcount(input logic [VCOUNT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        vcount_reg  = value;
        rows_taken  = 0;
    endtask

    // mix of empty, full, sparse and dense rows
    function automatic logic [ROW_W-1:0] random_row();
        int unsigned      pick;
        logic [ROW_W-1:0] bits;
        pick = $urandom_range(99);
        if (pick < 15)
            bits = '0;
        else if (pick < 25)
            bits = '1;
        else if (pick < 60) begin
            bits = '0;
            bits[$urandom_range(ROW_W-1)] = 1'b1;
            if ($urandom_range(1))
                bits[$urandom_range(ROW_W-1)] = 1'b1;
        end else
            bits = ROW_W'($urandom);
        return bits;
    endfunction

    // ------------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------------

    // default count after reset: a chain over all sixteen vertices, one
    // all-ones row in the middle, the top row empty
    task automatic test_default_count();
        for (int i = 0; i < MAX_VERTICES_DEF; i++) begin
            if (i == 7)
                send_row('1);
            else if (i == MAX_VERTICES_DEF - 1)
                send_row('0);
            else
                send_row(ROW_W'(1) << (i + 1));
        end
        wait_idle();
    endtask

    // count zero acts as one vertex; count two with a two-vertex cycle and
    // row bits beyond the count cleared
    task automatic test_count_extremes();
        write_vcount(5'd0);
        send_row('1);
        send_row('0);
        wait_idle();
        write_vcount(5'd2);
        send_row(16'hFFFE);
        send_row(16'h0001);
        wait_idle();
    endtask

    // register write in the middle of a set drops the rows already taken in
    task automatic test_load_restart();
        write_vcount(5'd3);
        send_row(16'h0006);
        send_row(16'h0004);
        wait_idle();
        write_vcount(5'd2);
        send_row(16'h0002);
        send_row(16'h0000);
        wait_idle();
    endtask

    // random counts and data sets under one idling pattern
    task automatic test_random_sets(input int unsigned send_pct,
                                    input int unsigned recv_pct,
                                    input int unsigned target_rows);
        int unsigned start_rows;
        int unsigned pick;
        int unsigned n;
        int unsigned partial;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start_rows    = rows_sent;
        while (rows_sent - start_rows < target_rows) begin
            // mostly small graphs, some large, a few zero or oversize counts
            pick = $urandom_range(99);
            if (pick < 60)
                write_vcount(5'($urandom_range(5, 1)));
            else if (pick < 80)
                write_vcount(5'($urandom_range(16, 6)));
            else if (pick < 88)
                write_vcount(5'd0);
            else
                write_vcount(5'($urandom_range(31, 17)));
            n = active_vertices();
            repeat ($urandom_range(3, 1)) begin
                for (int i = 0; i < n; i++)
                    send_row(random_row());
            end
            // now and then a broken set, cut short by a register write
            if (n > 1 && $urandom_range(9) == 0) begin
                partial = $urandom_range(n - 1, 1);
                for (int i = 0; i < partial; i++)
                    send_row(random_row());
            end
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------------
    initial begin
        vcount_reg = VCOUNT_RST;
        rows_taken = 0;
        for (int i = 0; i < MAX_VERTICES_DEF; i++)
            reach_rows[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with both sides idling, the receiver more often
        send_idle_pct = 23;
        recv_idle_pct = 61;
        test_default_count();
        test_count_extremes();
        test_load_restart();

        // random part: sender idles less, then more, then neither idles
        test_random_sets(23, 61, 95);
        test_random_sets(61, 23, 95);
        test_random_sets(0, 0, 95);

        // catch any stray result after the last expected one
        wait_idle();
        repeat (END_QUIET) @(posedge clk);
        if (error_count == 0 && closure_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
